// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is asserted.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also watches the reset cycles.
`define CHK_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/msdp_pkg.sv =====
package msdp_pkg;

  localparam int ROW_W     = 12;
  localparam int VAL_W     = 32;
  localparam int ACC_W     = 64;
  localparam int IN_DATA_W = 48;  // row_index + entry_value, padded to whole bytes

  typedef enum logic [1:0] {
    ACT_SCATTER = 2'd0,
    ACT_GATHER  = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_EMPTY   = 2'd3
  } action_t;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Two's complement add that clamps to the signed range on overflow.
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W-1:0] s;
    s = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      return a[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

endpackage

// ===== hdl/msdp_store.sv =====
module msdp_store
  import msdp_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [VAL_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/masked_sparse_dot_product_engine.sv =====
// Masked sparse dot-product engine. The host streams one beat per CSC entry:
// in_tuser selects scatter (store a B value at row_index), gather (multiply the
// stored value at row_index by an A value and add it into a saturating Q32.32
// accumulator), clear (zero one stored entry) or empty column (emit zero).
// A gather with in_tlast set emits the dot product on out_tdata and clears the
// accumulator; an empty-column beat also clears it. Rows at or beyond
// VECTOR_DEPTH are ignored by scatter and clear and read as zero by gather.
// Scatter and clear finish when accepted, an empty-column beat passes through
// S_EMIT and a gather through store read, registered 32x32 multiply and
// saturating add; one beat is in flight at a time, and a result only waits for
// the output register when a previous result has not yet been taken. After
// reset the store is zeroed one entry per cycle with in_tready held low.
module masked_sparse_dot_product_engine
  import msdp_pkg::*;
#(
  parameter int VECTOR_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // [11:0] row_index, [43:12] entry_value, [47:44] zero
  input  logic [1:0]           in_tuser,   // [1:0] action
  input  logic                 in_tlast,   // last_entry
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [ACC_W-1:0]     out_tdata   // [63:0] dot_product
);

  localparam int AW = $clog2(VECTOR_DEPTH);
  localparam int CW = ((AW > ROW_W) ? AW : ROW_W) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(VECTOR_DEPTH - 1);

  typedef enum logic [2:0] {
    S_WIPE,
    S_IDLE,
    S_MUL,
    S_ADD,
    S_EMIT
  } state_t;

  state_t            state_r;
  logic [AW-1:0]     wipe_cnt_r;
  logic [VAL_W-1:0]  value_r;
  logic              last_r;
  logic              hit_r;
  logic [ACC_W-1:0]  prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic              out_valid_r;
  logic [ACC_W-1:0]  out_data_r;

  action_t             act;
  logic [ROW_W-1:0]    row;
  logic [VAL_W-1:0]    value;
  logic [CW-1:0]       row_ext;
  logic                in_range;
  logic [AW-1:0]       addr;
  logic                in_acc;
  logic                out_free;
  logic                out_load;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [VAL_W-1:0]    mem_wdata;
  logic                mem_re;
  logic [VAL_W-1:0]    rd_data;

  logic signed [VAL_W-1:0] opnd_s;
  logic signed [VAL_W-1:0] value_s;
  logic signed [ACC_W-1:0] prod_nxt;
  logic [ACC_W-1:0]        sum;

  assign act      = action_t'(in_tuser);
  assign row      = in_tdata[ROW_W-1:0];
  assign value    = in_tdata[ROW_W+VAL_W-1:ROW_W];
  assign row_ext  = CW'(row);
  assign in_range = row_ext < CW'(VECTOR_DEPTH);
  assign addr     = row_ext[AW-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  // a new result beat enters the output register this cycle
  assign out_load  = out_free && (((state_r == S_ADD) && last_r) || (state_r == S_EMIT));

  // Zero the store after reset, then take scatter and clear writes.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = value;
    if (state_r == S_WIPE) begin
      mem_we    = 1'b1;
      mem_waddr = wipe_cnt_r;
      mem_wdata = '0;
    end else if (in_acc && in_range) begin
      case (act)
        ACT_SCATTER: mem_we = 1'b1;
        ACT_CLEAR: begin
          mem_we    = 1'b1;
          mem_wdata = '0;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  assign mem_re = in_acc && (act == ACT_GATHER);

  msdp_store #(
    .DEPTH (VECTOR_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // Out-of-range rows read as zero.
  always_comb begin
    opnd_s   = hit_r ? $signed(rd_data) : '0;
    value_s  = $signed(value_r);
    prod_nxt = opnd_s * value_s;
  end

  assign sum = sat_add(acc_r, prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WIPE;
      wipe_cnt_r  <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_WIPE: begin
          wipe_cnt_r <= wipe_cnt_r + 1'b1;
          if (wipe_cnt_r == LAST_ADDR) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            case (act)
              ACT_GATHER: begin
                value_r <= value;
                last_r  <= in_tlast;
                hit_r   <= in_range;
                state_r <= S_MUL;
              end
              ACT_EMPTY: state_r <= S_EMIT;
              default:   state_r <= S_IDLE;
            endcase
          end
        end
        S_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (!last_r) begin
            acc_r   <= sum;
            state_r <= S_IDLE;
          end else if (out_free) begin
            // hold the sum until the output register frees up
            out_data_r  <= sum;
            out_valid_r <= 1'b1;
            acc_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_data_r  <= '0;
            out_valid_r <= 1'b1;
            acc_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/msdp_checker.sv =====
`include "assert_macros.svh"

module msdp_checker
  import msdp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [1:0]       in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [ACC_W-1:0] out_tdata
);

  logic in_beat;

  assign in_beat = in_tvalid && in_tready;

  // Stalled result beat must hold.
  `CHK_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // Reset drops any pending result and starts the store sweep.
  `CHK_ASSERT_RST(a_rst_out, clk, !rst_n |=> !out_tvalid, "result valid right after reset")
  `CHK_ASSERT_RST(a_rst_sweep, clk, !rst_n |=> !in_tready, "input taken during store sweep")

  // Empty column with a free output gives a zero beat.
  `CHK_ASSERT(a_empty_zero, clk, rst_n, in_beat && (in_tuser == ACT_EMPTY) && !out_tvalid |-> ##2 (out_tvalid && (out_tdata == '0)), "empty column did not emit zero")

  // Scatter never produces a beat.
  `CHK_ASSERT(a_scatter_quiet, clk, rst_n, in_beat && (in_tuser == ACT_SCATTER) && !out_tvalid |=> !out_tvalid, "scatter produced a result")

endmodule

bind masked_sparse_dot_product_engine msdp_checker u_msdp_checker (.*);

// ===== dv/masked_sparse_dot_product_engine_tb.sv =====
module masked_sparse_dot_product_engine_tb;
  import msdp_pkg::*;

  localparam int VEC_DEPTH   = 4096;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;  // [11:0] row_index, [43:12] entry_value, [47:44] zero
  logic [1:0]           in_tuser   = ACT_SCATTER;  // [1:0] action
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [ACC_W-1:0]     out_tdata;  // [63:0] dot_product

  masked_sparse_dot_product_engine #(
    .VECTOR_DEPTH(VEC_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Shadow of the dense column store and the running dot product.
  logic [VAL_W-1:0] col_values [VEC_DEPTH];
  longint           running_sum;
  logic [ACC_W-1:0] pending_dots [$];

  int  err_count    = 0;
  int  beats_sent   = 0;
  int  cycle_count  = 0;
  int  gap_pct      = 0;
  int  stall_pct    = 0;
  int  hold_request = 0;
  int  hold_left    = 0;
  logic [ACC_W-1:0] want_dot;

  function automatic longint clamp_add(longint a, longint b);
    longint s;
    s = a + b;
    if (((a < 0) == (b < 0)) && ((s < 0) != (a < 0))) begin
      return (a < 0) ? longint'(ACC_MIN) : longint'(ACC_MAX);
    end
    return s;
  endfunction

  task automatic predict_dot(action_t act, logic [ROW_W-1:0] row, logic [VAL_W-1:0] val,
                             logic last);
    longint stored_v;
    longint prod;
    case (act)
      ACT_SCATTER: begin
        if (row < VEC_DEPTH) col_values[row] = val;
      end
      ACT_CLEAR: begin
        if (row < VEC_DEPTH) col_values[row] = '0;
      end
      ACT_GATHER: begin
        stored_v = 0;
        if (row < VEC_DEPTH) stored_v = $signed(col_values[row]);
        prod = stored_v * longint'($signed(val));
        running_sum = clamp_add(running_sum, prod);
        if (last) begin
          pending_dots.push_back(running_sum);
          running_sum = 0;
        end
      end
      default: begin
        // empty column drops any partial sum
        running_sum = 0;
        pending_dots.push_back('0);
      end
    endcase
  endtask

  task automatic send_beat(action_t act, logic [ROW_W-1:0] row, logic [VAL_W-1:0] val,
                           logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {4'b0, val, row};
    in_tuser  = act;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    predict_dot(act, row, val, last);
    beats_sent++;
  endtask

  function automatic logic [ROW_W-1:0] pick_row();
    case ($urandom_range(0, 3))
      0, 1:    return ROW_W'($urandom_range(0, 15));
      2:       return ROW_W'($urandom_range(VEC_DEPTH - 16, VEC_DEPTH - 1));
      default: return ROW_W'($urandom_range(0, VEC_DEPTH - 1));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      // small Q16.16 values keep most sums in range
      1, 2, 3: return VAL_W'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_dots.size() == 0) begin
        $error("dot_product: expected none, got %h", out_tdata);
        err_count++;
      end else begin
        want_dot = pending_dots.pop_front();
        if (out_tdata !== want_dot) begin
          $error("dot_product: expected %h, got %h", want_dot, out_tdata);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("masked_sparse_dot_product_engine_tb: errors");
      $finish;
    end
  end

  task automatic test_directed_edges();
    send_beat(ACT_SCATTER, 12'd0,    32'h7FFF_FFFF, 1'b0);
    send_beat(ACT_SCATTER, 12'd4095, 32'h8000_0000, 1'b1);  // last ignored
    send_beat(ACT_SCATTER, 12'hAAA,  32'h0001_0000, 1'b0);
    send_beat(ACT_GATHER,  12'd0,    32'h0001_0000, 1'b0);
    send_beat(ACT_GATHER,  12'd4095, 32'hFFFF_FFFF, 1'b0);
    send_beat(ACT_GATHER,  12'h555,  32'h7FFF_FFFF, 1'b1);  // unwritten row reads zero
    send_beat(ACT_CLEAR,   12'd4095, 32'hFFFF_FFFF, 1'b1);
    send_beat(ACT_GATHER,  12'd4095, 32'h8000_0000, 1'b1);
    send_beat(ACT_GATHER,  12'hAAA,  32'h0002_0000, 1'b0);
    send_beat(ACT_EMPTY,   12'hFFF,  32'h1234_5678, 1'b0);  // drops the partial sum
    send_beat(ACT_GATHER,  12'hAAA,  32'h0000_8000, 1'b1);
    send_beat(ACT_EMPTY,   12'd0,    32'h0000_0000, 1'b1);
    send_beat(ACT_EMPTY,   12'd1,    32'h0000_0000, 1'b0);
    send_beat(ACT_GATHER,  12'd0,    32'h0000_0000, 1'b1);
  endtask

  task automatic test_saturation();
    send_beat(ACT_SCATTER, 12'd7, 32'h8000_0000, 1'b0);
    send_beat(ACT_SCATTER, 12'd8, 32'h7FFF_FFFF, 1'b0);
    // clamp high, then stay clamped
    repeat (2) send_beat(ACT_GATHER, 12'd7, 32'h8000_0000, 1'b0);
    send_beat(ACT_GATHER, 12'd7, 32'h8000_0000, 1'b1);
    // clamp low
    repeat (2) send_beat(ACT_GATHER, 12'd7, 32'h7FFF_FFFF, 1'b0);
    send_beat(ACT_GATHER, 12'd7, 32'h7FFF_FFFF, 1'b1);
    // come back down from the clamp
    repeat (2) send_beat(ACT_GATHER, 12'd7, 32'h8000_0000, 1'b0);
    send_beat(ACT_GATHER, 12'd8, 32'h8000_0000, 1'b1);
  endtask

  // One B column: scatter, one to four masked dot products, then tidy the store.
  task automatic run_column();
    logic [ROW_W-1:0] rows [$];
    logic [ROW_W-1:0] row;
    int n_dots;
    int n_terms;
    repeat ($urandom_range(1, 8)) begin
      row = pick_row();
      rows.push_back(row);
      send_beat(ACT_SCATTER, row, pick_value(), 1'($urandom_range(0, 1)));
    end
    n_dots = $urandom_range(1, 4);
    for (int d = 0; d < n_dots; d++) begin
      n_terms = $urandom_range(1, 6);
      for (int t = 0; t < n_terms; t++) begin
        if ($urandom_range(0, 9) < 8) row = rows[$urandom_range(0, rows.size() - 1)];
        else row = pick_row();
        send_beat(ACT_GATHER, row, pick_value(), t == n_terms - 1);
        if ($urandom_range(0, 29) == 0) begin
          // noise in the middle of a sequence
          send_beat(action_t'($urandom_range(0, 3)), pick_row(), $urandom,
                    1'($urandom_range(0, 1)));
        end
      end
      if ($urandom_range(0, 5) == 0) begin
        send_beat(ACT_EMPTY, pick_row(), $urandom, 1'($urandom_range(0, 1)));
      end
    end
    foreach (rows[i]) begin
      if ($urandom_range(0, 9) < 7) begin
        send_beat(ACT_CLEAR, rows[i], $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_random_columns(int gap, int stall, int target);
    gap_pct   = gap;
    stall_pct = stall;
    while (beats_sent < target) run_column();
  endtask

  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_request = 300;
    send_beat(ACT_SCATTER, 12'd3, 32'h0003_0000, 1'b0);
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0) send_beat(ACT_EMPTY, 12'd3, $urandom, 1'b0);
      else send_beat(ACT_GATHER, 12'd3, pick_value(), 1'b1);
    end
  endtask

  initial begin
    for (int i = 0; i < VEC_DEPTH; i++) col_values[i] = '0;
    running_sum = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_saturation();
    test_random_columns(0,  0,  150);
    test_random_columns(61, 0,  280);
    test_random_columns(0,  61, 410);
    test_random_columns(11, 11, 530);
    test_backpressure();

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("masked_sparse_dot_product_engine_tb: clean");
    end else begin
      $display("masked_sparse_dot_product_engine_tb: errors");
    end
    $finish;
  end

endmodule
